FILE: rtl/tbot_pkg.sv
//------------------------------------------------------------------------------
// tbot_pkg
// types, commands and states shared by the box overlap test block
//------------------------------------------------------------------------------
package tbot_pkg;

	localparam int WordWidth = 32;
	localparam int FracBits  = 16;
	localparam int ProdWidth = 2 * WordWidth;
	// three products, a translation and a bound, with headroom
	localparam int AccWidth  = ProdWidth + 4;

	typedef enum logic [2:0] {
		CMD_LOAD_S2F = 3'd0,
		CMD_LOAD_F2S = 3'd1,
		CMD_LOAD_BOX = 3'd2,
		CMD_TEST_TR  = 3'd3,
		CMD_TEST_AL  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		SEP_NONE    = 2'd0,
		SEP_FIRST   = 2'd1,
		SEP_SECOND  = 2'd2,
		SEP_ALIGNED = 2'd3
	} sep_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_PASS_END,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       clr_flags;
		logic       pass;     // 0 second-to-first, 1 first-to-second
		logic [2:0] corner;
		logic [1:0] axis;
		logic [2:0] term;     // 0..2 products, 3 translation, 5 bound compare
		logic       aligned;
		logic       set_result;
		logic [1:0] result_by;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sep;
	} dp_sts_t;

endpackage

FILE: rtl/tbot_if.sv
//------------------------------------------------------------------------------
// tbot_in_if / tbot_out_if
// valid/ready channels of the box overlap test block
//------------------------------------------------------------------------------
interface tbot_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [1:0]  row_index;
	logic signed [31:0] val_a;
	logic signed [31:0] val_b;
	logic signed [31:0] val_c;
	logic signed [31:0] val_d;
	logic signed [31:0] val_e;
	logic signed [31:0] val_f;
	modport source (output valid, command, row_index, val_a, val_b, val_c, val_d,
		val_e, val_f, input ready);
	modport sink (input valid, command, row_index, val_a, val_b, val_c, val_d,
		val_e, val_f, output ready);
endinterface

interface tbot_out_if;
	logic       valid;
	logic       ready;
	logic       overlap;
	logic [1:0] separated_by;
	modport source (output valid, overlap, separated_by, input ready);
	modport sink (input valid, overlap, separated_by, output ready);
endinterface

FILE: rtl/tbot_datapath.sv
//------------------------------------------------------------------------------
// tbot_datapath
// matrix and box storage, shared multiply-accumulate and separation flags
//------------------------------------------------------------------------------
module tbot_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_take,
	input  logic [2:0]          command,
	input  logic [1:0]          row_index,
	input  logic signed [31:0]  val_a,
	input  logic signed [31:0]  val_b,
	input  logic signed [31:0]  val_c,
	input  logic signed [31:0]  val_d,
	input  logic signed [31:0]  val_e,
	input  logic signed [31:0]  val_f,
	input  tbot_pkg::dp_cmd_t   cmd,
	output tbot_pkg::dp_sts_t   sts,
	output logic                overlap,
	output logic [1:0]          separated_by
);

	localparam int W = tbot_pkg::WordWidth;
	localparam int A = tbot_pkg::AccWidth;

	logic signed [W-1:0] s2f_q [12];
	logic signed [W-1:0] f2s_q [12];
	logic signed [W-1:0] box1_q [6];
	logic signed [W-1:0] box2_q [6];
	logic [2:0]          above_q, below_q;
	logic signed [A-1:0] acc_q;
	logic signed [2*W-1:0] prod_s1;
	logic                overlap_q;
	logic [1:0]          by_q;

	logic signed [W-1:0] mat_a, pt, bnd_hi, bnd_lo;
	logic signed [W-1:0] src [6];
	logic signed [W-1:0] dst [6];
	logic [3:0]          midx;
	logic [1:0]          psel;
	logic signed [A-1:0] d_hi, d_lo;
	logic                al_ov;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			src[i] = cmd.pass ? box1_q[i] : box2_q[i];
			dst[i] = cmd.pass ? box2_q[i] : box1_q[i];
		end
		midx = {cmd.axis, 2'b00} + {1'b0, cmd.term[1:0]};
		mat_a = cmd.pass ? f2s_q[midx] : s2f_q[midx];
		psel = cmd.term[1:0];
		case (psel)
			2'd0:    pt = cmd.corner[0] ? src[3] : src[0];
			2'd1:    pt = cmd.corner[1] ? src[4] : src[1];
			2'd2:    pt = cmd.corner[2] ? src[5] : src[2];
			default: pt = W'(1) <<< tbot_pkg::FracBits;
		endcase
		bnd_hi = dst[3 + cmd.axis];
		bnd_lo = dst[cmd.axis];
		d_hi = acc_q - (A'(bnd_hi) <<< tbot_pkg::FracBits);
		d_lo = acc_q - (A'(bnd_lo) <<< tbot_pkg::FracBits);
		al_ov = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (box1_q[i] > box2_q[3+i]) al_ov = 1'b0;
			if (box2_q[i] > box1_q[3+i]) al_ov = 1'b0;
		end
		sts.sep = |(above_q | below_q);
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			case (command)
				tbot_pkg::CMD_LOAD_S2F: if (row_index != 2'd3) begin
					s2f_q[{row_index, 2'd0}] <= val_a;
					s2f_q[{row_index, 2'd1}] <= val_b;
					s2f_q[{row_index, 2'd2}] <= val_c;
					s2f_q[{row_index, 2'd3}] <= val_d;
				end
				tbot_pkg::CMD_LOAD_F2S: if (row_index != 2'd3) begin
					f2s_q[{row_index, 2'd0}] <= val_a;
					f2s_q[{row_index, 2'd1}] <= val_b;
					f2s_q[{row_index, 2'd2}] <= val_c;
					f2s_q[{row_index, 2'd3}] <= val_d;
				end
				tbot_pkg::CMD_LOAD_BOX: begin
					box1_q[0] <= val_a; box1_q[1] <= val_b; box1_q[2] <= val_c;
					box1_q[3] <= val_d; box1_q[4] <= val_e; box1_q[5] <= val_f;
				end
				default: begin
					box2_q[0] <= val_a; box2_q[1] <= val_b; box2_q[2] <= val_c;
					box2_q[3] <= val_d; box2_q[4] <= val_e; box2_q[5] <= val_f;
				end
			endcase
		end
		// product stage, then accumulate
		prod_s1 <= mat_a * pt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			above_q   <= '0;
			below_q   <= '0;
			overlap_q <= 1'b0;
			by_q      <= 2'd0;
		end else begin
			if (cmd.clr_flags) begin
				above_q <= 3'b111;
				below_q <= 3'b111;
			end
			// term 1 loads, terms 2..4 add, the product issued the cycle before
			if (cmd.term == 3'd1) acc_q <= A'(prod_s1);
			else if (cmd.term == 3'd2 || cmd.term == 3'd3 || cmd.term == 3'd4)
				acc_q <= acc_q + A'(prod_s1);
			if (cmd.term == 3'd5) begin
				if (!(d_hi > 0)) above_q[cmd.axis] <= 1'b0;
				if (!(d_lo < 0)) below_q[cmd.axis] <= 1'b0;
			end
			if (cmd.set_result) begin
				if (cmd.aligned) begin
					overlap_q <= al_ov;
					by_q      <= al_ov ? tbot_pkg::SEP_NONE : tbot_pkg::SEP_ALIGNED;
				end else begin
					overlap_q <= (cmd.result_by == tbot_pkg::SEP_NONE);
					by_q      <= cmd.result_by;
				end
			end
		end
	end

	assign overlap      = overlap_q;
	assign separated_by = by_q;

endmodule

FILE: rtl/tbot_ctrl.sv
//------------------------------------------------------------------------------
// tbot_ctrl
// sequencer over passes, corners, axes and terms of the shared mac
//------------------------------------------------------------------------------
module tbot_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2:0]        command,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output tbot_pkg::dp_cmd_t cmd,
	input  tbot_pkg::dp_sts_t sts
);

	tbot_pkg::state_t state_q, state_d;
	logic       pass_q, pass_d;
	logic [2:0] corner_q, corner_d;
	logic [1:0] axis_q, axis_d;
	logic [2:0] term_q, term_d;
	logic       take;

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tbot_pkg::ST_IDLE;
			pass_q   <= 1'b0;
			corner_q <= '0;
			axis_q   <= '0;
			term_q   <= '0;
		end else begin
			state_q  <= state_d;
			pass_q   <= pass_d;
			corner_q <= corner_d;
			axis_q   <= axis_d;
			term_q   <= term_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		corner_d = corner_q;
		axis_d   = axis_q;
		term_d   = term_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		cmd.pass   = pass_q;
		cmd.corner = corner_q;
		cmd.axis   = axis_q;
		case (state_q)
			tbot_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.term = 3'd7;
				if (take) begin
					if (command == tbot_pkg::CMD_TEST_TR) begin
						state_d = tbot_pkg::ST_MAC;
						pass_d = 1'b0; corner_d = '0; axis_d = '0; term_d = '0;
						cmd.clr_flags = 1'b1;
					end else if (command == tbot_pkg::CMD_TEST_AL) begin
						state_d = tbot_pkg::ST_PASS_END;
						pass_d = 1'b1;
						term_d = 3'd7;
					end
				end
			end
			tbot_pkg::ST_MAC: begin
				cmd.term = term_q;
				if (term_q == 3'd5) begin
					term_d = '0;
					if (axis_q == 2'd2) begin
						axis_d = '0;
						if (corner_q == 3'd7) begin
							corner_d = '0;
							state_d = tbot_pkg::ST_PASS_END;
						end else
							corner_d = corner_q + 3'd1;
					end else
						axis_d = axis_q + 2'd1;
				end else
					term_d = term_q + 3'd1;
			end
			tbot_pkg::ST_PASS_END: begin
				cmd.term = 3'd7;
				if (term_q == 3'd7) begin
					cmd.aligned = 1'b1;
					cmd.set_result = 1'b1;
					state_d = tbot_pkg::ST_OUT;
				end else if (sts.sep) begin
					cmd.set_result = 1'b1;
					cmd.result_by = pass_q ? tbot_pkg::SEP_SECOND : tbot_pkg::SEP_FIRST;
					state_d = tbot_pkg::ST_OUT;
				end else if (pass_q) begin
					cmd.set_result = 1'b1;
					cmd.result_by = tbot_pkg::SEP_NONE;
					state_d = tbot_pkg::ST_OUT;
				end else begin
					pass_d = 1'b1;
					cmd.clr_flags = 1'b1;
					state_d = tbot_pkg::ST_MAC;
				end
			end
			tbot_pkg::ST_OUT: begin
				cmd.term = 3'd7;
				out_valid = 1'b1;
				if (out_ready) state_d = tbot_pkg::ST_IDLE;
			end
			default: state_d = tbot_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == tbot_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");
	a_out_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("no return to idle");
`endif

endmodule

FILE: rtl/transformed_box_overlap_test_top.sv
//------------------------------------------------------------------------------
// transformed_box_overlap_test_top
// oriented box overlap test by corner transforms on a shared mac
//------------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | command, row_index, val_a..val_f
// out_ch  | out | overlap, separated_by
//
// loads are stored as taken, staying in idle; an aligned test goes from idle
// through ST_PASS_END to ST_OUT; a transformed test runs up to two passes over
// 8 corners, 3 axes and 6 mac steps on the single shared multiply-accumulate unit
// one item at a time; the result is held until out_ch.ready
// arst_n clears control, accumulator, flags and result; stored matrices and box are undefined until loaded
//------------------------------------------------------------------------------
module transformed_box_overlap_test_top (
	input  logic      clk,
	input  logic      arst_n,
	tbot_in_if.sink   in_ch,
	tbot_out_if.source out_ch
);

	tbot_pkg::dp_cmd_t cmd;
	tbot_pkg::dp_sts_t sts;

	tbot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.command   (in_ch.command),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tbot_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_take      (in_ch.valid && in_ch.ready),
		.command      (in_ch.command),
		.row_index    (in_ch.row_index),
		.val_a        (in_ch.val_a),
		.val_b        (in_ch.val_b),
		.val_c        (in_ch.val_c),
		.val_d        (in_ch.val_d),
		.val_e        (in_ch.val_e),
		.val_f        (in_ch.val_f),
		.cmd          (cmd),
		.sts          (sts),
		.overlap      (out_ch.overlap),
		.separated_by (out_ch.separated_by)
	);

endmodule

FILE: dv/transformed_box_overlap_test_top_test.sv
//------------------------------------------------------------------------------
// transformed_box_overlap_test_top_test
// self-checking bench for the oriented box overlap test block: loads matrix
// rows and the first box, runs transformed and aligned tests, and checks
// every result against an exact wide-integer prediction
//------------------------------------------------------------------------------
module transformed_box_overlap_test_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int One = 1 << tbot_pkg::FracBits;
	localparam int WatchLimit = 6000;
	localparam int DrainCycles = 400;

	typedef logic signed [31:0] word_t;
	typedef word_t mat_t[12];
	typedef word_t box_t[6];

	typedef struct {
		logic [2:0] command;
		logic [1:0] row_index;
		word_t      v[6];
	} box_item_t;

	typedef struct {
		logic       overlap;
		logic [1:0] separated_by;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tbot_in_if  in_ch();
	tbot_out_if out_ch();

	transformed_box_overlap_test_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	box_item_t pending_items[$];
	verdict_t  verdicts_due[$];
	mat_t      s2f_rows;
	mat_t      f2s_rows;
	box_t      first_box;
	int        errors = 0;
	int        items_in = 0;
	int        verdicts_seen = 0;
	int        sep_count[4] = '{0, 0, 0, 0};
	int        quiet_cycles = 0;
	int        hold_left = 0;
	bit        hold_done = 0;

	function automatic int idle_pct(input bit sender);
		case (items_in / 330)
			0: return 0;
			1: return sender ? 55 : 0;
			2: return sender ? 0 : 55;
			default: return 29;
		endcase
	endfunction

	// sign of (row . p + t) - bound, exact
	function automatic int corner_sign(input mat_t m, input int j, input word_t p[3],
			input word_t bound);
		logic signed [71:0] acc;
		logic signed [71:0] a;
		logic signed [71:0] b;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			a = m[j * 4 + i];
			b = p[i];
			acc = acc + a * b;
		end
		a = m[j * 4 + 3];
		acc = acc + (a <<< tbot_pkg::FracBits);
		a = bound;
		acc = acc - (a <<< tbot_pkg::FracBits);
		if (acc < 0) return -1;
		return (acc == 0) ? 0 : 1;
	endfunction

	function automatic bit corners_split(input mat_t m, input box_t src, input box_t dst);
		bit above[3];
		bit below[3];
		word_t p[3];
		above = '{1, 1, 1};
		below = '{1, 1, 1};
		for (int k = 0; k < 8; k++) begin
			p[0] = (k & 1) ? src[3] : src[0];
			p[1] = (k & 2) ? src[4] : src[1];
			p[2] = (k & 4) ? src[5] : src[2];
			for (int j = 0; j < 3; j++) begin
				if (!(corner_sign(m, j, p, dst[3 + j]) > 0)) above[j] = 0;
				if (!(corner_sign(m, j, p, dst[j]) < 0)) below[j] = 0;
			end
		end
		for (int j = 0; j < 3; j++)
			if (above[j] || below[j]) return 1;
		return 0;
	endfunction

	function automatic void predict_overlap(input box_item_t it);
		box_t     second;
		verdict_t r;
		for (int i = 0; i < 6; i++) second[i] = it.v[i];
		case (it.command)
			tbot_pkg::CMD_LOAD_S2F, tbot_pkg::CMD_LOAD_F2S: begin
				if (it.row_index <= 2)
					for (int i = 0; i < 4; i++)
						if (it.command == tbot_pkg::CMD_LOAD_S2F)
							s2f_rows[it.row_index * 4 + i] = it.v[i];
						else f2s_rows[it.row_index * 4 + i] = it.v[i];
			end
			tbot_pkg::CMD_LOAD_BOX: first_box = second;
			tbot_pkg::CMD_TEST_TR: begin
				r.separated_by = tbot_pkg::SEP_NONE;
				if (corners_split(s2f_rows, second, first_box))
					r.separated_by = tbot_pkg::SEP_FIRST;
				else if (corners_split(f2s_rows, first_box, second))
					r.separated_by = tbot_pkg::SEP_SECOND;
				r.overlap = (r.separated_by == tbot_pkg::SEP_NONE);
				verdicts_due.push_back(r);
			end
			tbot_pkg::CMD_TEST_AL: begin
				r.overlap = 1;
				for (int i = 0; i < 3; i++) begin
					if (!(first_box[i] <= second[3 + i])) r.overlap = 0;
					if (!(second[i] <= first_box[3 + i])) r.overlap = 0;
				end
				r.separated_by = r.overlap ? tbot_pkg::SEP_NONE : tbot_pkg::SEP_ALIGNED;
				verdicts_due.push_back(r);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	// driver
	box_item_t offered;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= '0;
			in_ch.row_index <= '0;
			{in_ch.val_a, in_ch.val_b, in_ch.val_c} <= '0;
			{in_ch.val_d, in_ch.val_e, in_ch.val_f} <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				predict_overlap(offered);
				items_in++;
			end
			if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct(1)) begin
				offered = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.command <= offered.command;
				in_ch.row_index <= offered.row_index;
				in_ch.val_a <= offered.v[0];
				in_ch.val_b <= offered.v[1];
				in_ch.val_c <= offered.v[2];
				in_ch.val_d <= offered.v[3];
				in_ch.val_e <= offered.v[4];
				in_ch.val_f <= offered.v[5];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left > 0) hold_left <= hold_left - 1;
		else if (!hold_done && items_in >= 200) begin
			hold_done <= 1;
			hold_left <= 500;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = verdicts_due.pop_front();
					if (out_ch.overlap !== want.overlap)
						report_mismatch($sformatf("overlap got %b want %b",
							out_ch.overlap, want.overlap));
					if (out_ch.separated_by !== want.separated_by)
						report_mismatch($sformatf("separated_by got %0d want %0d",
							out_ch.separated_by, want.separated_by));
					sep_count[want.separated_by]++;
				end
			end
			out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(0));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("watchdog: no transfer for %0d cycles", WatchLimit);
			$display("transformed_box_overlap_test_top_test: errors");
			$finish;
		end
	end

	function automatic word_t near(input int span);
		return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
	endfunction

	function automatic word_t any_word();
		return word_t'($urandom);
	endfunction

	task automatic add_item(input logic [2:0] c, input logic [1:0] r, input word_t a,
			input word_t b, input word_t cc, input word_t d, input word_t e, input word_t f);
		box_item_t it;
		it.command = c;
		it.row_index = r;
		it.v = '{a, b, cc, d, e, f};
		pending_items.push_back(it);
	endtask

	task automatic add_identity(input logic [2:0] c, input word_t shift);
		for (int r = 0; r < 3; r++)
			add_item(c, 2'(r), r == 0 ? One : 0, r == 1 ? One : 0, r == 2 ? One : 0,
				r == 0 ? shift : 0, 0, 0);
	endtask

	task automatic add_random_item();
		int pick;
		word_t lo[3];
		pick = $urandom_range(99);
		for (int i = 0; i < 3; i++) lo[i] = near(4 * One);
		if (pick < 40)
			add_item(tbot_pkg::CMD_TEST_TR, 2'($urandom), lo[0], lo[1], lo[2],
				lo[0] + near(2 * One) + One, lo[1] + near(2 * One) + One,
				lo[2] + near(2 * One) + One);
		else if (pick < 55)
			add_item(tbot_pkg::CMD_TEST_AL, 2'($urandom), lo[0], lo[1], lo[2],
				lo[0] + near(2 * One), lo[1] + near(2 * One), lo[2] + near(2 * One));
		else if (pick < 82)
			add_item($urandom_range(0, 1) ? tbot_pkg::CMD_LOAD_S2F : tbot_pkg::CMD_LOAD_F2S,
				2'($urandom_range(0, 2)), near(One + One / 2), near(One + One / 2),
				near(One + One / 2), near(3 * One), any_word(), any_word());
		else if (pick < 90)
			add_item(tbot_pkg::CMD_LOAD_BOX, 2'($urandom), lo[0], lo[1], lo[2],
				lo[0] + near(2 * One) + One, lo[1] + near(2 * One) + One,
				lo[2] + near(2 * One) + One);
		else
			add_item(3'($urandom_range(0, 7)), 2'($urandom), any_word(), any_word(),
				any_word(), any_word(), any_word(), any_word());
	endtask

	localparam word_t WMin = 32'sh8000_0000;
	localparam word_t WMax = 32'sh7fff_ffff;

	initial begin
		// directed: identity frames, unit first box
		add_identity(tbot_pkg::CMD_LOAD_S2F, 0);
		add_identity(tbot_pkg::CMD_LOAD_F2S, 0);
		add_item(tbot_pkg::CMD_LOAD_BOX, 2'd0, 0, 0, 0, One, One, One);
		add_item(tbot_pkg::CMD_TEST_AL, 2'd0, One / 2, One / 2, One / 2,
			2 * One, 2 * One, 2 * One);
		add_item(tbot_pkg::CMD_TEST_AL, 2'd0, 2 * One, 0, 0, 3 * One, One, One);
		add_item(tbot_pkg::CMD_TEST_AL, 2'd0, 0, 0, -3 * One, One, One, -One);
		add_item(tbot_pkg::CMD_TEST_AL, 2'd0, One, One, One, 2 * One, 2 * One, 2 * One);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, One / 2, One / 2, One / 2,
			2 * One, 2 * One, 2 * One);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, One, 0, 0, 2 * One, One, One);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, 0, 3 * One, 0, One, 4 * One, One);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, 0, 0, WMin, One, One, -One);
		// first frame overlaps, second frame pushes the first box away
		add_item(tbot_pkg::CMD_LOAD_F2S, 2'd0, One, 0, 0, 100 * One, 0, 0);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, 0, 0, 0, One, One, One);
		add_item(tbot_pkg::CMD_LOAD_F2S, 2'd3, WMax, WMin, WMax, WMin, WMax, WMin);
		add_item(3'(tbot_pkg::CMD_TEST_AL) + 3'd1, 2'd0, 0, 0, 0, 0, 0, 0);
		add_item(3'(tbot_pkg::CMD_TEST_AL) + 3'd2, 2'd1, WMax, WMax, WMax, WMax, WMax, WMax);
		add_item(3'(tbot_pkg::CMD_TEST_AL) + 3'd3, 2'd2, WMin, WMin, WMin, WMin, WMin, WMin);
		// extreme matrix and inverted box
		add_item(tbot_pkg::CMD_LOAD_S2F, 2'd1, WMax, WMin, WMax, WMin, 0, 0);
		add_item(tbot_pkg::CMD_LOAD_BOX, 2'd0, One, One, One, -One, -One, -One);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, WMin, WMin, WMin, WMax, WMax, WMax);
		add_item(tbot_pkg::CMD_TEST_AL, 2'd0, WMax, WMax, WMax, WMin, WMin, WMin);
		add_item(tbot_pkg::CMD_LOAD_BOX, 2'd0, WMin, WMin, WMin, WMax, WMax, WMax);
		add_item(tbot_pkg::CMD_TEST_TR, 2'd0, -One, -One, -One, One, One, One);
		for (int n = 0; n < 1280; n++) add_random_item();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() > 0 || in_ch.valid) @(posedge clk);
		while (verdicts_due.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("%0d items in, %0d results checked", items_in, verdicts_seen);
		$display("verdicts: overlap %0d, first frame %0d, second frame %0d, aligned %0d",
			sep_count[0], sep_count[1], sep_count[2], sep_count[3]);
		if (errors == 0 && verdicts_due.size() == 0)
			$display("transformed_box_overlap_test_top_test: clean");
		else
			$display("transformed_box_overlap_test_top_test: errors");
		$finish;
	end

endmodule
